// File: rtl/encoder_angle_velocity_estimator_core_assert.svh
// Assertion macros for the encoder angle/velocity estimator core.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef ENCODER_ANGLE_VELOCITY_ESTIMATOR_CORE_ASSERT_SVH
`define ENCODER_ANGLE_VELOCITY_ESTIMATOR_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define EAVE_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("eave assertion failed");
`define EAVE_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("eave assertion failed");
`else
`define EAVE_ASSERT(lbl, clk, rstn, prop)
`define EAVE_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: rtl/eave_pkg.sv
// Shared constants and controller/datapath interface types for the
// encoder angle/velocity estimator core. No dependencies.
package eave_pkg;

    localparam int ANGLE_W   = 14;
    localparam int RAW_W     = 16;
    localparam int TIME_W    = 32;
    localparam int VEL_W     = 33;
    localparam int DIFF_W    = 16;
    localparam int VNUM_W    = 20;
    localparam int PROD_W    = 33;
    localparam int DIV_STEPS = 32;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [VNUM_W-1:0] VEL_NUM   = VNUM_W'(703125);
    localparam logic signed [DIFF_W-1:0] HALF_TURN = DIFF_W'(8192);
    localparam logic signed [DIFF_W-1:0] FULL_TURN = DIFF_W'(16384);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    typedef struct packed {
        logic accept;
        logic prep;
        logic prime;
        logic div_start;
        logic div_step;
        logic finish;
        logic load_out;
        logic upd;
    } eave_cmd_t;

    typedef struct packed {
        logic primed;
        logic dt_zero;
    } eave_sts_t;

endpackage

// File: rtl/eave_ctrl.sv
// Sequencing controller for the estimator: handshakes, step counter, commands.
// Depends on eave_pkg and the assertion macro header.
`include "encoder_angle_velocity_estimator_core_assert.svh"

module eave_ctrl
    import eave_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  eave_sts_t sts,
    output eave_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DECIDE,
        ST_DIV,
        ST_FIN,
        ST_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             upd_reg, upd_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic             slot_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign slot_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        upd_next      = upd_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        cmd.upd       = upd_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                upd_next = 1'b0;
                if (!sts.primed) begin
                    cmd.prime  = 1'b1;
                    state_next = ST_DONE;
                end else if (sts.dt_zero) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.div_start = 1'b1;
                    cnt_next      = '0;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                cmd.finish = 1'b1;
                upd_next   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (slot_free) begin
                    cmd.load_out  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            upd_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            upd_reg      <= upd_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    `EAVE_ASSERT(a_load_slot_free, aclk, aresetn, cmd.load_out |-> slot_free)
    `EAVE_ASSERT(a_accept_to_prep, aclk, aresetn, s_tvalid && s_tready |=> state_reg == ST_PREP)
    `EAVE_ASSERT(a_start_to_div, aclk, aresetn, cmd.div_start |=> cnt_reg == '0)
    `EAVE_ASSERT(a_div_to_fin, aclk, aresetn, cmd.div_step && cnt_reg == CNT_LAST |=> cmd.finish)
    `EAVE_ASSERT(a_upd_after_fin, aclk, aresetn, cmd.finish |=> cmd.upd)

endmodule

// File: rtl/eave_dp.sv
// Datapath for the estimator: sample state, wrapped difference, scale multiply,
// radix-2 restoring divider and output register. Depends on eave_pkg.
module eave_dp
    import eave_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [2*RAW_W+TIME_W-RAW_W-1:0] s_tdata,
    input  eave_cmd_t                cmd,
    output eave_sts_t                sts,
    output logic [ANGLE_W-1:0]       out_angle,
    output logic [VEL_W-1:0]         out_vel,
    output logic                     out_upd
);

    logic [ANGLE_W-1:0] in_angle_reg;
    logic [TIME_W-1:0]  in_time_reg;
    logic [ANGLE_W-1:0] prev_angle_reg;
    logic [TIME_W-1:0]  prev_time_reg;
    logic               primed_reg;
    logic [VEL_W-1:0]   held_reg;
    logic [TIME_W-1:0]  dt_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic               neg_reg;
    logic [TIME_W-1:0]  rem_reg;
    logic [TIME_W-1:0]  quo_reg;
    logic [ANGLE_W-1:0] out_angle_reg;
    logic [VEL_W-1:0]   out_vel_reg;
    logic               out_upd_reg;

    logic signed [DIFF_W-1:0] diff_raw;
    logic signed [DIFF_W-1:0] diff_wrap;
    logic [ANGLE_W-1:0]       mag;
    logic [TIME_W:0]          rem_sh;
    logic                     ge;
    logic [VEL_W-1:0]         vel_mag;

    always_comb begin
        diff_raw = $signed({2'b00, in_angle_reg}) - $signed({2'b00, prev_angle_reg});
        if (diff_raw > HALF_TURN) begin
            diff_wrap = diff_raw - FULL_TURN;
        end else if (diff_raw < -HALF_TURN) begin
            diff_wrap = diff_raw + FULL_TURN;
        end else begin
            diff_wrap = diff_raw;
        end
        if (diff_wrap[DIFF_W-1]) begin
            mag = ANGLE_W'(-diff_wrap);
        end else begin
            mag = ANGLE_W'(diff_wrap);
        end
    end

    assign rem_sh  = {rem_reg, quo_reg[TIME_W-1]};
    assign ge      = (rem_sh >= {1'b0, dt_reg});
    assign vel_mag = {1'b0, quo_reg};

    assign sts.primed  = primed_reg;
    assign sts.dt_zero = (dt_reg == '0);

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            in_angle_reg <= s_tdata[ANGLE_W-1:0];
            in_time_reg  <= s_tdata[RAW_W +: TIME_W];
        end
        if (cmd.prep) begin
            dt_reg   <= in_time_reg - prev_time_reg;
            prod_reg <= PROD_W'(mag) * PROD_W'(VEL_NUM);
            neg_reg  <= diff_wrap[DIFF_W-1];
        end
        if (cmd.div_start) begin
            rem_reg <= '0;
            quo_reg <= prod_reg[PROD_W-1:1];
        end else if (cmd.div_step) begin
            rem_reg <= ge ? TIME_W'(rem_sh - {1'b0, dt_reg}) : rem_sh[TIME_W-1:0];
            quo_reg <= {quo_reg[TIME_W-2:0], ge};
        end
        if (cmd.load_out) begin
            out_angle_reg <= in_angle_reg;
            out_vel_reg   <= held_reg;
            out_upd_reg   <= cmd.upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_angle_reg <= '0;
            prev_time_reg  <= '0;
            primed_reg     <= 1'b0;
            held_reg       <= '0;
        end else begin
            if (cmd.prime || cmd.finish) begin
                prev_angle_reg <= in_angle_reg;
                prev_time_reg  <= in_time_reg;
            end
            if (cmd.prime) begin
                primed_reg <= 1'b1;
            end
            if (cmd.finish) begin
                held_reg <= neg_reg ? VEL_W'(-vel_mag) : vel_mag;
            end
        end
    end

    assign out_angle = out_angle_reg;
    assign out_vel   = out_vel_reg;
    assign out_upd   = out_upd_reg;

endmodule

// File: rtl/encoder_angle_velocity_estimator_core.sv
// Encoder angle/velocity estimator core: one result per accepted sample. The
// angle is the low 14 bits of the raw word; velocity (1/16 deg/s) is the
// half-turn-wrapped count difference times 351562.5 over the elapsed
// microseconds, truncated toward zero, and held when no update happens (first
// sample or zero elapsed time). A sample with a fresh velocity runs through
// accept, prep, decide, the 32-step radix-2 divider and finish; others skip
// the divider. A finished result waits in the output register while the next
// sample runs. Depends on eave_pkg, eave_ctrl and eave_dp.
module encoder_angle_velocity_estimator_core
    import eave_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [15:0] raw_word, [47:16] timestamp_us
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [13:0] angle_counts, [46:14] velocity, [47] zero
    output logic        m_tuser    // [0] velocity_updated
);

    eave_cmd_t          cmd;
    eave_sts_t          sts;
    logic [ANGLE_W-1:0] out_angle;
    logic [VEL_W-1:0]   out_vel;
    logic               out_upd;

    eave_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    eave_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_angle (out_angle),
        .out_vel   (out_vel),
        .out_upd   (out_upd)
    );

    assign m_tdata = {1'b0, out_vel, out_angle};
    assign m_tuser = out_upd;

endmodule

// File: bench/encoder_angle_velocity_estimator_core_tb.sv
// Self-checking bench for encoder_angle_velocity_estimator_core: drives raw encoder words with
// timestamps over the stream input, predicts angle and velocity, and checks each result.
// Depends on eave_pkg and the RTL of the core.
import eave_pkg::*;

class velocity_scoreboard;
    typedef struct {
        logic [ANGLE_W-1:0]        angle;
        logic signed [VEL_W-1:0]   velocity;
        logic                      updated;
    } reading_t;

    localparam longint unsigned SCALE_NUM = 703125;
    localparam int              HALF_COUNTS = 8192;
    localparam int              FULL_COUNTS = 16384;

    reading_t                  pending_readings[$];
    logic [ANGLE_W-1:0]        last_angle;
    logic [TIME_W-1:0]         last_time;
    logic                      has_prior;
    logic signed [VEL_W-1:0]   held_velocity;
    int unsigned               failures;

    function new();
        last_angle    = '0;
        last_time     = '0;
        has_prior     = 1'b0;
        held_velocity = '0;
        failures      = 0;
    endfunction

    function logic signed [VEL_W-1:0] scaled_velocity(int d, logic [TIME_W-1:0] dt);
        longint unsigned mag;
        longint unsigned den;
        longint unsigned q;
        logic signed [VEL_W-1:0] v;
        mag = (d < 0) ? longint'(-d) : longint'(d);
        den = {32'd0, dt} << 1;
        q = (mag * SCALE_NUM) / den;
        v = VEL_W'(q);
        if (d < 0) begin
            v = -v;
        end
        return v;
    endfunction

    function void note_sample(logic [RAW_W-1:0] raw, logic [TIME_W-1:0] stamp);
        reading_t          r;
        logic [TIME_W-1:0] dt;
        int                d;
        r.angle   = raw[ANGLE_W-1:0];
        r.updated = 1'b0;
        if (!has_prior) begin
            last_angle = r.angle;
            last_time  = stamp;
            has_prior  = 1'b1;
        end else begin
            dt = stamp - last_time;
            if (dt != '0) begin
                d = int'(r.angle) - int'(last_angle);
                if (d > HALF_COUNTS) begin
                    d -= FULL_COUNTS;
                end else if (d < -HALF_COUNTS) begin
                    d += FULL_COUNTS;
                end
                held_velocity = scaled_velocity(d, dt);
                last_angle    = r.angle;
                last_time     = stamp;
                r.updated     = 1'b1;
            end
        end
        r.velocity = held_velocity;
        pending_readings.push_back(r);
    endfunction

    function void check_result(logic [47:0] data, logic flag);
        reading_t want;
        if (pending_readings.size() == 0) begin
            failures++;
            if (failures <= 10) begin
                $display("unexpected result: data %h updated %b", data, flag);
            end
            return;
        end
        want = pending_readings.pop_front();
        if (data[13:0] !== want.angle || data[46:14] !== want.velocity
                || data[47] !== 1'b0 || flag !== want.updated) begin
            failures++;
            if (failures <= 10) begin
                $display({"mismatch: angle exp %0d got %0d, velocity exp %0d got %0d, ",
                          "updated exp %b got %b, pad %b"},
                         want.angle, data[13:0], want.velocity, $signed(data[46:14]),
                         want.updated, flag, data[47]);
            end
        end
    endfunction

    function int pending();
        return pending_readings.size();
    endfunction
endclass

module encoder_angle_velocity_estimator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1335;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 600000;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        m_tuser;

    velocity_scoreboard sb = new();
    logic               long_hold = 1'b0;
    int unsigned        cycle_count = 0;

    encoder_angle_velocity_estimator_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_sample(s_tdata[15:0], s_tdata[47:16]);
            end
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata, m_tuser);
            end
        end
    end

    initial begin : receiver
        int unsigned phase;
        phase = 0;
        m_tready = 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (long_hold) begin
                long_hold = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                case (phase[7:6])
                    2'd0: m_tready <= 1'b1;
                    2'd1: m_tready <= ($urandom_range(0, 3) != 0);
                    2'd2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= phase[2];
                endcase
                phase++;
                @(posedge aclk);
            end
        end
    end

    task automatic offer_sample(input logic [15:0] raw, input logic [31:0] stamp);
        s_tvalid <= 1'b1;
        s_tdata  <= {stamp, raw};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    initial begin : stimulus
        logic [13:0] cur_angle;
        logic [31:0] cur_ts;
        logic [13:0] ang;
        logic [31:0] ts;
        int          sent;
        int          burst;
        int          gap;
        int          pick;
        bit          hold_done;
        bit          pause_done;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        offer_sample(16'hFFFF, 32'hFFFF_FFF0);
        offer_sample(16'h0000, 32'h0000_0005);
        offer_sample(16'h1234, 32'h0000_0005);
        offer_sample(16'hE000, 32'h0000_0006);
        offer_sample(16'h0000, 32'h0000_0007);
        offer_sample(16'h2001, 32'h0000_0008);
        offer_sample(16'h0000, 32'h0000_0009);
        offer_sample(16'h8005, 32'h8000_0009);
        offer_sample(16'h4005, 32'h8000_0008);
        offer_sample(16'h7FFF, 32'h8000_0009);
        offer_sample(16'hBFFF, 32'h8000_0009);
        offer_sample(16'h3FFE, 32'h8000_000A);
        offer_sample(16'h3FFF, 32'h8000_000D);
        offer_sample(16'h1FFF, 32'hFFFF_FFFF);
        offer_sample(16'h5555, 32'h0000_0000);
        offer_sample(16'hAAAA, 32'h5555_5555);
        offer_sample(16'h0000, 32'hAAAA_AAAA);
        cur_angle = 14'h0000;
        cur_ts    = 32'hAAAA_AAAA;
        s_tvalid <= 1'b0;
        wait_drained();

        sent       = 0;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    ts = cur_ts;
                end else if (pick < 20) begin
                    ts = $urandom;
                end else if (pick < 28) begin
                    ts = cur_ts + $urandom_range(1, 3);
                end else begin
                    ts = cur_ts + $urandom_range(1, 5000);
                end
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    ang = cur_angle + 14'($urandom_range(0, 600) - 300);
                end else if (pick < 55) begin
                    ang = cur_angle + 14'($urandom_range(8191, 8193));
                end else begin
                    ang = 14'($urandom);
                end
                offer_sample({2'($urandom_range(0, 3)), ang}, ts);
                cur_angle = ang;
                cur_ts    = ts;
                sent++;
            end
            if (!hold_done && sent >= 400) begin
                hold_done = 1'b1;
                long_hold = 1'b1;
            end
            if (!pause_done && sent >= 800) begin
                pause_done = 1'b1;
                s_tvalid <= 1'b0;
                wait_drained();
            end else if ($urandom_range(0, 2) != 0) begin
                gap = $urandom_range(1, 40);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
